// ===== rtl/core/rcc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcc_pkg
// Shared types, widths, codes and helpers of the RGB color classifier.
// ----------------------------------------------------------------------------
package rcc_pkg;

    // Sample and gain formats
    localparam int SAMPLE_BITS    = 16;
    localparam int GAIN_FRAC_BITS = 12;
    localparam int FIELD_W        = 16;
    localparam int CFG_W          = 16;
    localparam int SHARE_FRAC_W   = 16;

    // Datapath widths
    localparam int PROD_W   = SAMPLE_BITS + CFG_W;        // balanced channel
    localparam int TOT_W    = PROD_W + 2;                 // sum of three channels
    localparam int SPROD_W  = TOT_W + CFG_W;              // share * total
    localparam int FLOOR_W  = CFG_W + GAIN_FRAC_BITS;     // floor in fixed point
    localparam int CMP_W    = (PROD_W > FLOOR_W) ? PROD_W : FLOOR_W;
    localparam int SCMP_W   = (PROD_W + SHARE_FRAC_W > SPROD_W) ?
                              (PROD_W + SHARE_FRAC_W) : SPROD_W;

    // Configuration port
    localparam int NUM_REGS   = 8;
    localparam int REG_IDX_W  = 3;
    localparam int PADDR_W    = REG_IDX_W + 2;
    localparam int PDATA_W    = 32;

    localparam logic [REG_IDX_W-1:0] REG_GAIN_RED        = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_GREEN      = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_BLUE       = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_MIN_CLEAR_LEVEL = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_CHANNEL_FLOOR   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_RED_SHARE_MIN   = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_GREEN_SHARE_MIN = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_BLUE_SHARE_MIN  = 3'd7;

    // Register reset values
    localparam logic [CFG_W-1:0] RST_GAIN        = 16'd4096;
    localparam logic [CFG_W-1:0] RST_MIN_CLEAR   = 16'd50;
    localparam logic [CFG_W-1:0] RST_FLOOR       = 16'd200;
    localparam logic [CFG_W-1:0] RST_RED_SHARE   = 16'd29491;
    localparam logic [CFG_W-1:0] RST_OTHER_SHARE = 16'd26214;

    // Class codes
    localparam logic [2:0] CLASS_NONE    = 3'd0;
    localparam logic [2:0] CLASS_RED     = 3'd1;
    localparam logic [2:0] CLASS_GREEN   = 3'd2;
    localparam logic [2:0] CLASS_BLUE    = 3'd3;
    localparam logic [2:0] CLASS_UNKNOWN = 3'd4;

    // Ejector codes
    localparam logic [1:0] EJECT_RED   = 2'd0;
    localparam logic [1:0] EJECT_GREEN = 2'd1;
    localparam logic [1:0] EJECT_BLUE  = 2'd2;
    localparam logic [1:0] EJECT_BIN   = 2'd3;

    // Channel beats
    typedef struct packed {
        logic [FIELD_W-1:0] red_level;
        logic [FIELD_W-1:0] green_level;
        logic [FIELD_W-1:0] blue_level;
        logic [FIELD_W-1:0] clear_level;
    } t_in_beat;

    typedef struct packed {
        logic [2:0] color_class;
        logic [1:0] ejector_channel;
    } t_out_beat;

    // Register set seen by the stages
    typedef struct packed {
        logic [CFG_W-1:0] gain_red;
        logic [CFG_W-1:0] gain_green;
        logic [CFG_W-1:0] gain_blue;
        logic [CFG_W-1:0] min_clear_level;
        logic [CFG_W-1:0] channel_floor;
        logic [CFG_W-1:0] red_share_min;
        logic [CFG_W-1:0] green_share_min;
        logic [CFG_W-1:0] blue_share_min;
    } t_cfg;

    // Stage 1 -> 2: balanced channels
    typedef struct packed {
        logic              clear_ok;
        logic [PROD_W-1:0] fr;
        logic [PROD_W-1:0] fg;
        logic [PROD_W-1:0] fb;
    } t_bal;

    // Stage 2 -> 3: balanced channels and total
    typedef struct packed {
        logic              none;
        logic [PROD_W-1:0] fr;
        logic [PROD_W-1:0] fg;
        logic [PROD_W-1:0] fb;
        logic [TOT_W-1:0]  total;
    } t_tot;

    // Stage 3 -> 4: share products and pre-qualified winners (r, g, b)
    typedef struct packed {
        logic               none;
        logic [2:0]         pre;
        logic [PROD_W-1:0]  fr;
        logic [PROD_W-1:0]  fg;
        logic [PROD_W-1:0]  fb;
        logic [SPROD_W-1:0] pr;
        logic [SPROD_W-1:0] pg;
        logic [SPROD_W-1:0] pb;
    } t_shr;

    // Ejector channel for a class
    function automatic logic [1:0] ejector_for(input logic [2:0] cls);
        logic [1:0] ej;
        case (cls)
            CLASS_RED:   ej = EJECT_RED;
            CLASS_GREEN: ej = EJECT_GREEN;
            CLASS_BLUE:  ej = EJECT_BLUE;
            default:     ej = EJECT_BIN;
        endcase
        return ej;
    endfunction

endpackage

// ===== rtl/core/rcc_gain_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcc_gain_stage
// Stage 1: white-balance multiplies and the clear-level presence test.
// ----------------------------------------------------------------------------
module rcc_gain_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rcc_pkg::t_cfg     i_cfg,
    input  logic              i_valid,
    output logic              o_ready,
    input  rcc_pkg::t_in_beat i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output rcc_pkg::t_bal     o_data
);
    import rcc_pkg::*;

    logic r_valid;
    t_bal r_data;
    t_bal n_data;

    // Stage holds when full and downstream stalls
    assign o_ready = !r_valid || i_ready;

    // Gains applied to the low sample bits
    always_comb begin
        n_data.clear_ok = CFG_W'(i_data.clear_level[SAMPLE_BITS-1:0]) >=
                          i_cfg.min_clear_level;
        n_data.fr = PROD_W'(i_data.red_level[SAMPLE_BITS-1:0]) * PROD_W'(i_cfg.gain_red);
        n_data.fg = PROD_W'(i_data.green_level[SAMPLE_BITS-1:0]) *
                    PROD_W'(i_cfg.gain_green);
        n_data.fb = PROD_W'(i_data.blue_level[SAMPLE_BITS-1:0]) * PROD_W'(i_cfg.gain_blue);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== rtl/core/rcc_total_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcc_total_stage
// Stage 2: balanced total and the no-object / dark decision.
// ----------------------------------------------------------------------------
module rcc_total_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  rcc_pkg::t_bal i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output rcc_pkg::t_tot o_data
);
    import rcc_pkg::*;

    localparam logic [TOT_W-1:0] DARK_LIMIT = TOT_W'(1) << GAIN_FRAC_BITS;

    logic             r_valid;
    t_tot             r_data;
    t_tot             n_data;
    logic [TOT_W-1:0] sum;

    assign o_ready = !r_valid || i_ready;

    // Sum of the three balanced channels
    always_comb begin
        sum = TOT_W'(i_data.fr) + TOT_W'(i_data.fg) + TOT_W'(i_data.fb);
        n_data.none  = !i_data.clear_ok || (sum < DARK_LIMIT);
        n_data.fr    = i_data.fr;
        n_data.fg    = i_data.fg;
        n_data.fb    = i_data.fb;
        n_data.total = sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== rtl/core/rcc_share_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcc_share_stage
// Stage 3: share-threshold products, dominance and floor tests.
// ----------------------------------------------------------------------------
module rcc_share_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  rcc_pkg::t_cfg i_cfg,
    input  logic          i_valid,
    output logic          o_ready,
    input  rcc_pkg::t_tot i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output rcc_pkg::t_shr o_data
);
    import rcc_pkg::*;

    logic             r_valid;
    t_shr             r_data;
    t_shr             n_data;
    logic [CMP_W-1:0] floor_fx;
    logic [CMP_W-1:0] xr;
    logic [CMP_W-1:0] xg;
    logic [CMP_W-1:0] xb;

    assign o_ready = !r_valid || i_ready;

    // Threshold times total; strict dominance and floor in parallel
    always_comb begin
        floor_fx = CMP_W'(i_cfg.channel_floor) << GAIN_FRAC_BITS;
        xr = CMP_W'(i_data.fr);
        xg = CMP_W'(i_data.fg);
        xb = CMP_W'(i_data.fb);
        n_data.none   = i_data.none;
        n_data.pre[2] = (xr > floor_fx) && (xr > xg) && (xr > xb);
        n_data.pre[1] = (xg > floor_fx) && (xg > xr) && (xg > xb);
        n_data.pre[0] = (xb > floor_fx) && (xb > xr) && (xb > xg);
        n_data.fr = i_data.fr;
        n_data.fg = i_data.fg;
        n_data.fb = i_data.fb;
        n_data.pr = SPROD_W'(i_cfg.red_share_min) * SPROD_W'(i_data.total);
        n_data.pg = SPROD_W'(i_cfg.green_share_min) * SPROD_W'(i_data.total);
        n_data.pb = SPROD_W'(i_cfg.blue_share_min) * SPROD_W'(i_data.total);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== rtl/core/rcc_decide_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcc_decide_stage
// Stage 4: share compares, red-green-blue priority and ejector mapping.
// Holds the output register of the block.
// ----------------------------------------------------------------------------
module rcc_decide_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  rcc_pkg::t_shr      i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output rcc_pkg::t_out_beat o_data
);
    import rcc_pkg::*;

    logic              r_valid;
    t_out_beat         r_data;
    t_out_beat         n_data;
    logic              win_r;
    logic              win_g;
    logic              win_b;
    logic [2:0]        cls;

    // Channel scaled to Q0.16 against threshold * total
    function automatic logic share_over(input logic [PROD_W-1:0]  x,
                                        input logic [SPROD_W-1:0] p);
        logic [SCMP_W-1:0] xs;
        xs = SCMP_W'(x) << SHARE_FRAC_W;
        return xs > SCMP_W'(p);
    endfunction

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        win_r = i_data.pre[2] && share_over(i_data.fr, i_data.pr);
        win_g = i_data.pre[1] && share_over(i_data.fg, i_data.pg);
        win_b = i_data.pre[0] && share_over(i_data.fb, i_data.pb);
        if (i_data.none) begin
            cls = CLASS_NONE;
        end else if (win_r) begin
            cls = CLASS_RED;
        end else if (win_g) begin
            cls = CLASS_GREEN;
        end else if (win_b) begin
            cls = CLASS_BLUE;
        end else begin
            cls = CLASS_UNKNOWN;
        end
        n_data.color_class     = cls;
        n_data.ejector_channel = ejector_for(cls);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== rtl/core/rgb_color_classifier_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_color_classifier_core
// Classifies one red/green/blue/clear reading as none, red, green, blue or
// unknown and names the ejector channel for it.
// ----------------------------------------------------------------------------
// A reading is accepted on i_in_valid/o_in_ready and its result leaves on
// o_out_valid/i_out_ready; one beat is taken every cycle in steady state
// while i_out_ready is high. The four register stages are: gain multiplies,
// total sum, threshold multiplies with dominance and floor tests, then share
// compares and priority. Each stage stalls only when it is full and the
// stage after it is stalled, so bubbles close up. Registers sit on the
// APB-style port at byte address 4*index (gains, clear minimum, floor, three
// share minimums) and should be written only while no beat is in flight.
// ----------------------------------------------------------------------------
module rgb_color_classifier_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rcc_pkg::PADDR_W-1:0]     paddr,
    input  logic [rcc_pkg::PDATA_W-1:0]     pwdata,
    output logic [rcc_pkg::PDATA_W-1:0]     prdata,
    output logic                            pready,
    // Reading channel
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  rcc_pkg::t_in_beat               i_in_data,
    // Result channel
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output rcc_pkg::t_out_beat              o_out_data
);
    import rcc_pkg::*;

    t_cfg                 r_cfg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic [CFG_W-1:0]     rd_val;

    logic s1_valid, s1_ready;
    logic s2_valid, s2_ready;
    logic s3_valid, s3_ready;
    t_bal s1_data;
    t_tot s2_data;
    t_shr s3_data;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_red        <= RST_GAIN;
            r_cfg.gain_green      <= RST_GAIN;
            r_cfg.gain_blue       <= RST_GAIN;
            r_cfg.min_clear_level <= RST_MIN_CLEAR;
            r_cfg.channel_floor   <= RST_FLOOR;
            r_cfg.red_share_min   <= RST_RED_SHARE;
            r_cfg.green_share_min <= RST_OTHER_SHARE;
            r_cfg.blue_share_min  <= RST_OTHER_SHARE;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                REG_GAIN_RED:        r_cfg.gain_red        <= pwdata[CFG_W-1:0];
                REG_GAIN_GREEN:      r_cfg.gain_green      <= pwdata[CFG_W-1:0];
                REG_GAIN_BLUE:       r_cfg.gain_blue       <= pwdata[CFG_W-1:0];
                REG_MIN_CLEAR_LEVEL: r_cfg.min_clear_level <= pwdata[CFG_W-1:0];
                REG_CHANNEL_FLOOR:   r_cfg.channel_floor   <= pwdata[CFG_W-1:0];
                REG_RED_SHARE_MIN:   r_cfg.red_share_min   <= pwdata[CFG_W-1:0];
                REG_GREEN_SHARE_MIN: r_cfg.green_share_min <= pwdata[CFG_W-1:0];
                REG_BLUE_SHARE_MIN:  r_cfg.blue_share_min  <= pwdata[CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Register reads
    always_comb begin
        case (reg_idx)
            REG_GAIN_RED:        rd_val = r_cfg.gain_red;
            REG_GAIN_GREEN:      rd_val = r_cfg.gain_green;
            REG_GAIN_BLUE:       rd_val = r_cfg.gain_blue;
            REG_MIN_CLEAR_LEVEL: rd_val = r_cfg.min_clear_level;
            REG_CHANNEL_FLOOR:   rd_val = r_cfg.channel_floor;
            REG_RED_SHARE_MIN:   rd_val = r_cfg.red_share_min;
            REG_GREEN_SHARE_MIN: rd_val = r_cfg.green_share_min;
            REG_BLUE_SHARE_MIN:  rd_val = r_cfg.blue_share_min;
            default:             rd_val = '0;
        endcase
    end

    assign prdata = PDATA_W'(rd_val);

    // Pipeline
    rcc_gain_stage u_gain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_data  (i_in_data),
        .o_valid (s1_valid),
        .i_ready (s1_ready),
        .o_data  (s1_data)
    );

    rcc_total_stage u_total (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .o_ready (s1_ready),
        .i_data  (s1_data),
        .o_valid (s2_valid),
        .i_ready (s2_ready),
        .o_data  (s2_data)
    );

    rcc_share_stage u_share (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (s2_valid),
        .o_ready (s2_ready),
        .i_data  (s2_data),
        .o_valid (s3_valid),
        .i_ready (s3_ready),
        .o_data  (s3_data)
    );

    rcc_decide_stage u_decide (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s3_valid),
        .o_ready (s3_ready),
        .i_data  (s3_data),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule

// ===== verif/rgb_color_classifier_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_color_classifier_core_tb
// Self-checking bench for the color classifier core. A short table of
// readings covers the corner cases at reset settings. Several register
// settings follow, from zero gains to all-ones thresholds, each with a
// batch of shaped random readings. Both channels stall in random bursts,
// and one long output stall backs the pipeline up. Every result beat is
// checked in order against the table result or an in-bench classifier.
// ----------------------------------------------------------------------------
module rgb_color_classifier_core_tb;

    import rcc_pkg::*;

    localparam int N_DIRECTED   = 22;
    localparam int N_PHASES     = 5;
    localparam int PHASE_ITEMS  = 136;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 120;
    localparam int HOLD_AFTER   = 200;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct packed {
        t_in_beat  beat;
        logic      typed;
        t_out_beat result;
    } t_directed_row;

    // Clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #5 clk = ~clk;

    // Bench-driven inputs, known from time zero
    logic                 apb_sel    = 1'b0;
    logic                 apb_enable = 1'b0;
    logic                 apb_write  = 1'b0;
    logic [PADDR_W-1:0]   apb_addr   = '0;
    logic [PDATA_W-1:0]   apb_wdata  = '0;
    logic                 in_valid   = 1'b0;
    t_in_beat             in_data    = '0;
    logic                 out_ready  = 1'b0;

    logic [PDATA_W-1:0]   apb_rdata;
    logic                 apb_ready;
    logic                 in_ready;
    logic                 out_valid;
    t_out_beat            out_data;

    // Bench state
    logic [CFG_W-1:0] cfg_shadow [NUM_REGS] = '{RST_GAIN, RST_GAIN, RST_GAIN, RST_MIN_CLEAR,
                                               RST_FLOOR, RST_RED_SHARE, RST_OTHER_SHARE,
                                               RST_OTHER_SHARE};
    t_out_beat pending_classes [$];
    int        fault_count       = 0;
    int        readings_accepted = 0;
    int        cycle_count       = 0;
    bit        idle_on           = 1'b1;
    bit        hold_done         = 1'b0;

    rgb_color_classifier_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .psel        (apb_sel),
        .penable     (apb_enable),
        .pwrite      (apb_write),
        .paddr       (apb_addr),
        .pwdata      (apb_wdata),
        .prdata      (apb_rdata),
        .pready      (apb_ready),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    // Corner readings at reset settings (red, green, blue, clear)
    t_directed_row directed_rows [N_DIRECTED] = '{
        // nothing in front of the sensor
        '{'{16'd0, 16'd0, 16'd0, 16'd0}, 1'b1, '{CLASS_NONE, EJECT_BIN}},
        // clear one below the minimum
        '{'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd49}, 1'b1, '{CLASS_NONE, EJECT_BIN}},
        // clear right at the minimum, but a dark total
        '{'{16'd0, 16'd0, 16'd0, 16'd50}, 1'b1, '{CLASS_NONE, EJECT_BIN}},
        '{'{16'hFFFF, 16'd0, 16'd0, 16'hFFFF}, 1'b1, '{CLASS_RED, EJECT_RED}},
        '{'{16'd0, 16'hFFFF, 16'd0, 16'hFFFF}, 1'b1, '{CLASS_GREEN, EJECT_GREEN}},
        '{'{16'd0, 16'd0, 16'hFFFF, 16'hFFFF}, 1'b1, '{CLASS_BLUE, EJECT_BLUE}},
        '{'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1, '{CLASS_UNKNOWN, EJECT_BIN}},
        // ties between two leaders
        '{'{16'd1000, 16'd1000, 16'd0, 16'd1000}, 1'b1, '{CLASS_UNKNOWN, EJECT_BIN}},
        '{'{16'd0, 16'd1000, 16'd1000, 16'd1000}, 1'b1, '{CLASS_UNKNOWN, EJECT_BIN}},
        '{'{16'd1000, 16'd0, 16'd1000, 16'd1000}, 1'b1, '{CLASS_UNKNOWN, EJECT_BIN}},
        // floor edge: one count above, then exactly on it
        '{'{16'd201, 16'd0, 16'd0, 16'd100}, 1'b1, '{CLASS_RED, EJECT_RED}},
        '{'{16'd200, 16'd0, 16'd0, 16'd100}, 1'b1, '{CLASS_UNKNOWN, EJECT_BIN}},
        // total of exactly 1.0 is not dark
        '{'{16'd1, 16'd0, 16'd0, 16'd50}, 1'b1, '{CLASS_UNKNOWN, EJECT_BIN}},
        '{'{16'd0, 16'd0, 16'd0, 16'hFFFF}, 1'b1, '{CLASS_NONE, EJECT_BIN}},
        // share edges and mixed bit patterns
        '{'{16'd450, 16'd275, 16'd275, 16'd500}, 1'b0, '0},
        '{'{16'd449, 16'd276, 16'd275, 16'd500}, 1'b0, '0},
        '{'{16'h8000, 16'h7FFF, 16'h1234, 16'hFFFF}, 1'b0, '0},
        '{'{16'hAAAA, 16'h5555, 16'h0F0F, 16'hF0F0}, 1'b0, '0},
        '{'{16'h5555, 16'hAAAA, 16'hF0F0, 16'h0F0F}, 1'b0, '0},
        '{'{16'd300, 16'd300, 16'd301, 16'd400}, 1'b0, '0},
        '{'{16'd100, 16'd900, 16'd100, 16'd8000}, 1'b0, '0},
        '{'{16'hFFFF, 16'hFFFE, 16'd0, 16'hFFFF}, 1'b0, '0}
    };

    // Share, floor and dominance tests for one balanced channel
    function automatic bit channel_dominates(input logic [63:0] x, input logic [63:0] y,
                                             input logic [63:0] z, input logic [63:0] total,
                                             input logic [CFG_W-1:0] share);
        logic [63:0] floor_fx;
        floor_fx = 64'(cfg_shadow[REG_CHANNEL_FLOOR]) << GAIN_FRAC_BITS;
        return ((x << SHARE_FRAC_W) > (64'(share) * total)) && (x > floor_fx) &&
               (x > y) && (x > z);
    endfunction

    // Expected class and ejector channel for one reading
    function automatic t_out_beat classify_reading(input t_in_beat rd);
        logic [63:0] fr, fg, fb, total;
        t_out_beat   res;
        fr    = 64'(rd.red_level) * 64'(cfg_shadow[REG_GAIN_RED]);
        fg    = 64'(rd.green_level) * 64'(cfg_shadow[REG_GAIN_GREEN]);
        fb    = 64'(rd.blue_level) * 64'(cfg_shadow[REG_GAIN_BLUE]);
        total = fr + fg + fb;
        if (rd.clear_level < cfg_shadow[REG_MIN_CLEAR_LEVEL]) begin
            res.color_class = CLASS_NONE;
        end else if (total < (64'd1 << GAIN_FRAC_BITS)) begin
            res.color_class = CLASS_NONE;
        end else if (channel_dominates(fr, fg, fb, total, cfg_shadow[REG_RED_SHARE_MIN])) begin
            res.color_class = CLASS_RED;
        end else if (channel_dominates(fg, fr, fb, total,
                                       cfg_shadow[REG_GREEN_SHARE_MIN])) begin
            res.color_class = CLASS_GREEN;
        end else if (channel_dominates(fb, fr, fg, total,
                                       cfg_shadow[REG_BLUE_SHARE_MIN])) begin
            res.color_class = CLASS_BLUE;
        end else begin
            res.color_class = CLASS_UNKNOWN;
        end
        case (res.color_class)
            CLASS_RED:   res.ejector_channel = EJECT_RED;
            CLASS_GREEN: res.ejector_channel = EJECT_GREEN;
            CLASS_BLUE:  res.ejector_channel = EJECT_BLUE;
            default:     res.ejector_channel = EJECT_BIN;
        endcase
        return res;
    endfunction

    // Random reading: one clear leader, near-share mixes, ties and
    // sparse channels, plus fully random noise
    function automatic t_in_beat random_reading();
        t_in_beat         rd;
        logic [15:0]      lvl [3];
        logic [15:0]      lead;
        int               p;
        rd     = {$urandom, $urandom};
        lvl[0] = rd.red_level;
        lvl[1] = rd.green_level;
        lvl[2] = rd.blue_level;
        p      = $urandom_range(0, 2);
        case ($urandom_range(0, 4))
            1: begin
                lead = 16'($urandom_range(64, 65535));
                for (int j = 0; j < 3; j++)
                    lvl[j] = (j == p) ? lead : 16'($urandom_range(0, int'(lead) / 2));
            end
            2: begin
                lvl[p]           = 16'($urandom_range(100, 65535));
                lvl[(p + 1) % 3] = lvl[p];
                lvl[(p + 2) % 3] = 16'($urandom_range(0, int'(lvl[p])));
            end
            3: begin
                for (int j = 0; j < 3; j++) begin
                    case ($urandom_range(0, 2))
                        0:       lvl[j] = 16'd0;
                        1:       lvl[j] = 16'($urandom_range(0, 3));
                        default: lvl[j] = 16'($urandom);
                    endcase
                end
            end
            4: begin
                lead = 16'($urandom_range(200, 30000));
                for (int j = 0; j < 3; j++)
                    lvl[j] = (j == p) ? lead :
                             16'((int'(lead) * $urandom_range(30, 95)) / 100);
            end
            default: ;
        endcase
        rd.red_level   = lvl[0];
        rd.green_level = lvl[1];
        rd.blue_level  = lvl[2];
        // clear near the no-object threshold part of the time
        case ($urandom_range(0, 3))
            0: rd.clear_level = cfg_shadow[REG_MIN_CLEAR_LEVEL] + 16'($urandom_range(0, 2))
                                - 16'd1;
            1: rd.clear_level = 16'hFFFF;
            2: rd.clear_level = 16'($urandom_range(0, 255));
            default: ;
        endcase
        return rd;
    endfunction

    // Register settings per phase: wide random, zero extremes, all-ones
    // extremes, then two realistic sets
    function automatic logic [NUM_REGS-1:0][CFG_W-1:0] phase_setting(input int ph);
        logic [NUM_REGS-1:0][CFG_W-1:0] s;
        case (ph)
            0: begin
                for (int j = 0; j < NUM_REGS; j++) s[j] = 16'($urandom);
            end
            1: begin
                s                      = '0;
                s[REG_GAIN_GREEN]      = RST_GAIN;
                s[REG_GAIN_BLUE]       = 16'hFFFF;
            end
            2: s = '1;
            default: begin
                s[REG_GAIN_RED]        = 16'($urandom_range(2048, 12000));
                s[REG_GAIN_GREEN]      = 16'($urandom_range(2048, 12000));
                s[REG_GAIN_BLUE]       = 16'($urandom_range(2048, 12000));
                s[REG_MIN_CLEAR_LEVEL] = 16'($urandom_range(0, 300));
                s[REG_CHANNEL_FLOOR]   = 16'($urandom_range(0, 1000));
                s[REG_RED_SHARE_MIN]   = 16'($urandom_range(20000, 40000));
                s[REG_GREEN_SHARE_MIN] = 16'($urandom_range(20000, 40000));
                s[REG_BLUE_SHARE_MIN]  = 16'($urandom_range(20000, 40000));
            end
        endcase
        return s;
    endfunction

    // One APB transfer; the bus stays selected so transfers can run back to back
    task automatic apb_transfer(input bit wr, input logic [REG_IDX_W-1:0] idx,
                                input logic [CFG_W-1:0] value);
        apb_sel    <= 1'b1;
        apb_enable <= 1'b0;
        apb_write  <= wr;
        apb_addr   <= {idx, 2'b00};
        apb_wdata  <= {16'($urandom), value};
        @(posedge clk);
        apb_enable <= 1'b1;
        do @(posedge clk); while (!apb_ready);
        if (wr) begin
            cfg_shadow[idx] = value;
        end else if (apb_rdata[CFG_W-1:0] !== cfg_shadow[idx]) begin
            if (fault_count < 10)
                $display("reg %0d readback: expected %0d, got %0d", idx, cfg_shadow[idx],
                         apb_rdata[CFG_W-1:0]);
            fault_count++;
        end
    endtask

    // Write the whole register set, then read it back
    task automatic program_settings(input logic [NUM_REGS-1:0][CFG_W-1:0] s);
        for (int j = 0; j < NUM_REGS; j++) apb_transfer(1'b1, REG_IDX_W'(j), s[j]);
        for (int j = 0; j < NUM_REGS; j++) apb_transfer(1'b0, REG_IDX_W'(j), '0);
        apb_sel    <= 1'b0;
        apb_enable <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one reading beat, with an optional idle burst ahead of it
    task automatic offer_reading(input t_in_beat rd, input bit typed,
                                 input t_out_beat typed_res);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= rd;
        do @(posedge clk); while (!in_ready);
        pending_classes.push_back(typed ? typed_res : classify_reading(rd));
        readings_accepted++;
    endtask

    // Stop offering and let every outstanding result come out
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_classes.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Main sequence
    initial begin : stimulus
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int k = 0; k < N_DIRECTED; k++)
            offer_reading(directed_rows[k].beat, directed_rows[k].typed,
                          directed_rows[k].result);
        for (int ph = 0; ph < N_PHASES; ph++) begin
            wait_drained();
            idle_on = (ph != N_PHASES - 1);
            program_settings(phase_setting(ph));
            for (int k = 0; k < PHASE_ITEMS; k++)
                offer_reading(random_reading(), 1'b0, '0);
        end
        wait_drained();
        if (fault_count == 0 && pending_classes.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Result side: ready bursts, short stalls, and one long stall mid-run
    initial begin : result_sink
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (!hold_done && readings_accepted >= HOLD_AFTER) begin
                hold_done = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end else begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    // Compare each result beat with the oldest expectation
    always @(posedge clk) begin : result_check
        t_out_beat want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_classes.size() == 0) begin
                if (fault_count < 10)
                    $display("unexpected result beat: class %0d ejector %0d",
                             out_data.color_class, out_data.ejector_channel);
                fault_count++;
            end else begin
                want = pending_classes.pop_front();
                if (out_data.color_class !== want.color_class ||
                    out_data.ejector_channel !== want.ejector_channel) begin
                    if (fault_count < 10)
                        $display("result mismatch: expected class %0d ejector %0d, got %0d %0d",
                                 want.color_class, want.ejector_channel,
                                 out_data.color_class, out_data.ejector_channel);
                    fault_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

endmodule
